// File: rtl/pkdf_pkg.sv
// shared types, codes and sizes for the per-key timestamp dedup filter
package pkdf_pkg;

    // number of symbol table entries
    localparam int SYMBOLS   = 256;
    localparam int IDX_W     = 8;
    localparam int TIME_W    = 63;
    localparam int CNT_W     = 32;
    localparam int FUNC_W    = 2;
    localparam int VERD_W    = 2;

    // table depth is bounded by what the index field can address
    localparam int TBL_DEPTH = (SYMBOLS < (1 << IDX_W)) ? SYMBOLS : (1 << IDX_W);
    localparam int TBL_AW    = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;

    localparam int IN_DATA_W  = ((IDX_W + TIME_W + 7) / 8) * 8;
    localparam int IN_USER_W  = FUNC_W;
    localparam int OUT_BITS   = VERD_W + 1 + TIME_W + 4 * CNT_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [FUNC_W-1:0] FN_PROCESS = 2'd0;
    localparam logic [FUNC_W-1:0] FN_CHECK   = 2'd1;
    localparam logic [FUNC_W-1:0] FN_CLEAR   = 2'd2;

    localparam logic [VERD_W-1:0] V_PASS = 2'd0;
    localparam logic [VERD_W-1:0] V_DUP  = 2'd1;
    localparam logic [VERD_W-1:0] V_LATE = 2'd2;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // controller to datapath
    typedef struct packed {
        logic load;   // capture item and read table entry
        logic exec;   // evaluate, update state, load result register
    } t_cmd;

endpackage

// File: rtl/pkdf_ctrl.sv
// controller: item sequencing and result valid for the dedup filter
module pkdf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    output logic           o_m_tvalid,
    input  logic           i_m_tready,
    output pkdf_pkg::t_cmd o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic fire;

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;

    // result register must be free, or emptied this cycle
    assign fire = (r_state == S_EXEC) && (!r_out_valid || i_m_tready);

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd.load  = 1'b0;
        o_cmd.exec  = 1'b0;
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (fire) begin
                    o_cmd.exec  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// File: rtl/pkdf_dp.sv
// datapath: symbol table, compare, counters and result register
module pkdf_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  pkdf_pkg::t_cmd                   i_cmd,
    input  logic [pkdf_pkg::FUNC_W-1:0]      i_func,
    input  logic [pkdf_pkg::IDX_W-1:0]       i_idx,
    input  logic [pkdf_pkg::TIME_W-1:0]      i_time,
    output logic [pkdf_pkg::VERD_W-1:0]      o_verdict,
    output logic                             o_seen_before,
    output logic [pkdf_pkg::TIME_W-1:0]      o_stored_time,
    output logic [pkdf_pkg::CNT_W-1:0]       o_received,
    output logic [pkdf_pkg::CNT_W-1:0]       o_passed,
    output logic [pkdf_pkg::CNT_W-1:0]       o_duplicate,
    output logic [pkdf_pkg::CNT_W-1:0]       o_late
);

    logic [pkdf_pkg::TIME_W-1:0]    r_mem [pkdf_pkg::TBL_DEPTH];
    logic [pkdf_pkg::TBL_DEPTH-1:0] r_seen;

    logic [pkdf_pkg::FUNC_W-1:0]    r_func;
    logic [pkdf_pkg::TBL_AW-1:0]    r_addr;
    logic                           r_valid_idx;
    logic [pkdf_pkg::TIME_W-1:0]    r_time;
    logic [pkdf_pkg::TIME_W-1:0]    r_mem_q;
    logic                           r_seen_q;

    logic [pkdf_pkg::CNT_W-1:0] r_rcv, r_pas, r_dup, r_lat;
    logic [pkdf_pkg::CNT_W-1:0] n_rcv, n_pas, n_dup, n_lat;

    logic [pkdf_pkg::VERD_W-1:0] r_verdict;
    logic                        r_out_seen;
    logic [pkdf_pkg::TIME_W-1:0] r_out_time;

    logic [pkdf_pkg::TBL_AW-1:0] in_addr;
    logic                        in_valid;
    logic [pkdf_pkg::TIME_W-1:0] prev;
    logic [pkdf_pkg::VERD_W-1:0] verdict;
    logic                        is_proc;
    logic                        is_clear;
    logic                        do_write;

    assign in_addr  = i_idx[pkdf_pkg::TBL_AW-1:0];
    assign in_valid = (32'(i_idx) < 32'(pkdf_pkg::SYMBOLS));

    assign prev     = r_seen_q ? r_mem_q : '0;
    assign is_proc  = (r_func == pkdf_pkg::FN_PROCESS);
    assign is_clear = (r_func == pkdf_pkg::FN_CLEAR);

    always_comb begin
        verdict = pkdf_pkg::V_PASS;
        if (r_seen_q) begin
            if (r_time == r_mem_q) begin
                verdict = pkdf_pkg::V_DUP;
            end else if (r_time < r_mem_q) begin
                verdict = pkdf_pkg::V_LATE;
            end
        end
    end

    assign do_write = i_cmd.exec && is_proc && (verdict == pkdf_pkg::V_PASS) && r_valid_idx;

    // saturating counter updates
    always_comb begin
        n_rcv = r_rcv;
        n_pas = r_pas;
        n_dup = r_dup;
        n_lat = r_lat;
        if (is_clear) begin
            n_rcv = '0;
            n_pas = '0;
            n_dup = '0;
            n_lat = '0;
        end else if (is_proc) begin
            if (r_rcv != pkdf_pkg::CNT_MAX) n_rcv = r_rcv + 1'b1;
            case (verdict)
                pkdf_pkg::V_PASS: if (r_pas != pkdf_pkg::CNT_MAX) n_pas = r_pas + 1'b1;
                pkdf_pkg::V_DUP:  if (r_dup != pkdf_pkg::CNT_MAX) n_dup = r_dup + 1'b1;
                default:          if (r_lat != pkdf_pkg::CNT_MAX) n_lat = r_lat + 1'b1;
            endcase
        end
    end

    // timestamp table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_mem[r_addr] <= r_time;
        end
        if (i_cmd.load) begin
            r_mem_q <= r_mem[in_addr];
        end
    end

    // seen flags and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
            r_rcv  <= '0;
            r_pas  <= '0;
            r_dup  <= '0;
            r_lat  <= '0;
        end else if (i_cmd.exec) begin
            r_rcv <= n_rcv;
            r_pas <= n_pas;
            r_dup <= n_dup;
            r_lat <= n_lat;
            if (is_clear) begin
                r_seen <= '0;
            end else if (do_write) begin
                r_seen[r_addr] <= 1'b1;
            end
        end
    end

    // item capture and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func      <= i_func;
            r_addr      <= in_addr;
            r_valid_idx <= in_valid;
            r_time      <= i_time;
            r_seen_q    <= in_valid && r_seen[in_addr];
        end
        if (i_cmd.exec) begin
            r_verdict  <= is_clear ? pkdf_pkg::V_PASS : verdict;
            r_out_seen <= r_seen_q;
            r_out_time <= prev;
        end
    end

    assign o_verdict     = r_verdict;
    assign o_seen_before = r_out_seen;
    assign o_stored_time = r_out_time;
    // counters only move on exec, which waits until the previous result is taken
    assign o_received    = r_rcv;
    assign o_passed      = r_pas;
    assign o_duplicate   = r_dup;
    assign o_late        = r_lat;

endmodule

// File: rtl/per_key_timestamp_dedup_filter.sv
// top level of the per-key timestamp dedup filter
// Per-key timestamp dedup filter. Each input item carries a function code in
// tuser (process, check, clear; code 3 acts as check) and a symbol index with
// an event time in tdata. The block keeps a seen flag and the last passed
// timestamp per symbol and returns exactly one result item per input item:
// verdict (pass, duplicate, out of order), whether the symbol was seen, the
// stored time before this item (zero if unseen) and four saturating counters
// as they stand after the item. A process item that passes stores its time;
// a clear item drops all seen flags and zeroes the counters. Each item takes
// a registered table read at the symbol index, then the compare, table write
// and counter update. Items are handled one at a time; a new item is taken
// while the previous result still waits in the output register, but its
// evaluation waits until that register is free. The seen flags are
// flip-flops cleared at reset, so no clearing pass is needed and the block
// is ready right after reset.
module per_key_timestamp_dedup_filter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input item stream
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // [7:0] symbol_index, [70:8] event_time, [71] zero
    input  logic [pkdf_pkg::IN_DATA_W-1:0]      i_s_tdata,
    // [1:0] func
    input  logic [pkdf_pkg::IN_USER_W-1:0]      i_s_tuser,
    // result item stream
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // [1:0] verdict, [2] seen_before, [65:3] stored_time,
    // [97:66] received_count, [129:98] passed_count,
    // [161:130] duplicate_count, [193:162] late_count, [199:194] zero
    output logic [pkdf_pkg::OUT_DATA_W-1:0]     o_m_tdata
);

    pkdf_pkg::t_cmd cmd;

    logic [pkdf_pkg::VERD_W-1:0] verdict;
    logic                        seen_before;
    logic [pkdf_pkg::TIME_W-1:0] stored_time;
    logic [pkdf_pkg::CNT_W-1:0]  received_count;
    logic [pkdf_pkg::CNT_W-1:0]  passed_count;
    logic [pkdf_pkg::CNT_W-1:0]  duplicate_count;
    logic [pkdf_pkg::CNT_W-1:0]  late_count;

    // sequencing: idle -> evaluate, result valid held until taken
    pkdf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (cmd)
    );

    // table, comparator, counters and result payload
    pkdf_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_func        (i_s_tuser[pkdf_pkg::FUNC_W-1:0]),
        .i_idx         (i_s_tdata[pkdf_pkg::IDX_W-1:0]),
        .i_time        (i_s_tdata[pkdf_pkg::IDX_W +: pkdf_pkg::TIME_W]),
        .o_verdict     (verdict),
        .o_seen_before (seen_before),
        .o_stored_time (stored_time),
        .o_received    (received_count),
        .o_passed      (passed_count),
        .o_duplicate   (duplicate_count),
        .o_late        (late_count)
    );

    // pack result fields, lowest field first, zero fill to a byte boundary
    assign o_m_tdata = {
        {(pkdf_pkg::OUT_DATA_W - pkdf_pkg::OUT_BITS){1'b0}},
        late_count,
        duplicate_count,
        passed_count,
        received_count,
        stored_time,
        seen_before,
        verdict
    };

endmodule

// File: rtl/pkdf_chk.sv
// port-level checker for the dedup filter, bound to the top level
module pkdf_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_tvalid,
    input logic                            o_s_tready,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [pkdf_pkg::OUT_DATA_W-1:0] o_m_tdata
);

    // a stalled result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // one item in flight: the input side is closed in the cycle after an accept
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input accepted while an item is in work");

    // verdict code is never the unused value
    a_verdict_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[1:0] == pkdf_pkg::V_PASS ||
                        o_m_tdata[1:0] == pkdf_pkg::V_DUP  ||
                        o_m_tdata[1:0] == pkdf_pkg::V_LATE))
        else $error("bad verdict code");

    // an unseen symbol reports a zero stored time and can only pass
    a_unseen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[2] |-> o_m_tdata[65:3] == '0 &&
                                        o_m_tdata[1:0] == pkdf_pkg::V_PASS)
        else $error("unseen symbol with stored time or drop");

endmodule

bind per_key_timestamp_dedup_filter pkdf_chk u_pkdf_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

// File: dv/pkdf_tb_pkg.sv
`timescale 1ns / 1ps
// result record and verdict scoreboard for the dedup filter testbench
package pkdf_tb_pkg;

    import pkdf_pkg::*;

    // laid out as on o_m_tdata, last field in the top bits
    typedef struct packed {
        logic [CNT_W-1:0]  late_count;
        logic [CNT_W-1:0]  duplicate_count;
        logic [CNT_W-1:0]  passed_count;
        logic [CNT_W-1:0]  received_count;
        logic [TIME_W-1:0] stored_time;
        logic              seen_before;
        logic [VERD_W-1:0] verdict;
    } t_dedup_result;

    class verdict_scoreboard;
        bit                seen_flags [SYMBOLS];
        logic [TIME_W-1:0] last_times [SYMBOLS];
        logic [CNT_W-1:0]  received_total;
        logic [CNT_W-1:0]  passed_total;
        logic [CNT_W-1:0]  duplicate_total;
        logic [CNT_W-1:0]  late_total;
        t_dedup_result     pending_verdicts [$];
        int                mismatch_count;

        function new();
            mismatch_count = 0;
            wipe_table();
        endfunction

        function void wipe_table();
            foreach (seen_flags[i]) begin
                seen_flags[i] = 1'b0;
                last_times[i] = '0;
            end
            received_total  = '0;
            passed_total    = '0;
            duplicate_total = '0;
            late_total      = '0;
        endfunction

        static function logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] c);
            return (c == CNT_MAX) ? c : c + 1'b1;
        endfunction

        // work out the result of one accepted item and update the table
        function void note_item(logic [FUNC_W-1:0] fn, logic [IDX_W-1:0] idx,
                                logic [TIME_W-1:0] t);
            t_dedup_result r;
            bit            in_range;
            r        = '0;
            r.verdict = V_PASS;
            in_range = int'(idx) < SYMBOLS;
            if (in_range && seen_flags[idx]) begin
                r.seen_before = 1'b1;
                r.stored_time = last_times[idx];
                if (t == r.stored_time)
                    r.verdict = V_DUP;
                else if (t < r.stored_time)
                    r.verdict = V_LATE;
            end
            if (fn == FN_CLEAR) begin
                wipe_table();
                r.verdict = V_PASS;
            end else if (fn == FN_PROCESS) begin
                received_total = sat_inc(received_total);
                if (r.verdict == V_PASS) begin
                    passed_total = sat_inc(passed_total);
                    if (in_range) begin
                        seen_flags[idx] = 1'b1;
                        last_times[idx] = t;
                    end
                end else if (r.verdict == V_DUP) begin
                    duplicate_total = sat_inc(duplicate_total);
                end else begin
                    late_total = sat_inc(late_total);
                end
            end
            r.received_count  = received_total;
            r.passed_count    = passed_total;
            r.duplicate_count = duplicate_total;
            r.late_count      = late_total;
            pending_verdicts.push_back(r);
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatch_count++;
            end
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] data);
            t_dedup_result want;
            t_dedup_result got;
            if (pending_verdicts.size() == 0) begin
                $error("result with no item pending: %h", data);
                mismatch_count++;
                return;
            end
            want = pending_verdicts.pop_front();
            got  = t_dedup_result'(data[OUT_BITS-1:0]);
            compare_field("verdict", 64'(want.verdict), 64'(got.verdict));
            compare_field("seen_before", 64'(want.seen_before), 64'(got.seen_before));
            compare_field("stored_time", 64'(want.stored_time), 64'(got.stored_time));
            compare_field("received_count", 64'(want.received_count),
                          64'(got.received_count));
            compare_field("passed_count", 64'(want.passed_count), 64'(got.passed_count));
            compare_field("duplicate_count", 64'(want.duplicate_count),
                          64'(got.duplicate_count));
            compare_field("late_count", 64'(want.late_count), 64'(got.late_count));
        endfunction
    endclass

endpackage

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// top of the dedup filter testbench: clock, reset, item drivers and checks
module tb_top;

    import pkdf_pkg::*;
    import pkdf_tb_pkg::*;

    // unused function code, the block treats it as a check
    localparam logic [FUNC_W-1:0] FN_SPARE = 2'd3;
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    // [7:0] symbol_index, [70:8] event_time, [71] zero
    logic [IN_DATA_W-1:0]  i_s_tdata  = '0;
    // [1:0] func
    logic [IN_USER_W-1:0]  i_s_tuser  = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    // [1:0] verdict, [2] seen_before, [65:3] stored_time, [97:66] received_count,
    // [129:98] passed_count, [161:130] duplicate_count, [193:162] late_count
    logic [OUT_DATA_W-1:0] o_m_tdata;

    verdict_scoreboard sb;
    int                src_idle_pct  = 0;
    int                sink_idle_pct = 0;
    logic              hold_request  = 1'b0;
    int                hold_left     = 0;
    int                cycle_count   = 0;
    logic [IDX_W-1:0]  hot_base      = '0;

    per_key_timestamp_dedup_filter u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold-off when asked
    always @(posedge i_clk) begin
        if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left  = hold_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // every accepted result goes against the oldest pending verdict
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_result(o_m_tdata);
    end

    // offer one item after a random gap and hold it until it is taken;
    // returns in the time step of the accepting edge
    task automatic send_item(input logic [FUNC_W-1:0] fn, input logic [IDX_W-1:0] idx,
                             input logic [TIME_W-1:0] t);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {1'b0, t, idx};
        i_s_tuser  <= fn;
        do
            @(posedge i_clk);
        while (!(i_s_tvalid && o_s_tready));
        sb.note_item(fn, idx, t);
    endtask

    task automatic run_directed();
        send_item(FN_PROCESS, 8'd0, '0);            // unseen symbol, zero time
        send_item(FN_PROCESS, 8'd0, '0);            // duplicate
        send_item(FN_CHECK, 8'd0, '0);              // check reports duplicate
        send_item(FN_PROCESS, 8'd0, 63'd5);         // newer time passes
        send_item(FN_PROCESS, 8'd0, 63'd3);         // older time is late
        send_item(FN_CHECK, 8'd0, 63'd2);
        send_item(FN_PROCESS, 8'd255, TIME_MAX);    // top index, top time
        send_item(FN_PROCESS, 8'd255, TIME_MAX);
        send_item(FN_PROCESS, 8'd255, TIME_MAX - 1'b1);
        send_item(FN_CHECK, 8'd255, '0);
        send_item(FN_SPARE, 8'd0, 63'd100);         // must not store
        send_item(FN_PROCESS, 8'd0, 63'd5);         // still a duplicate
        send_item(FN_CHECK, 8'd7, TIME_MAX);        // check on unseen symbol
        send_item(FN_PROCESS, 8'd128, 63'h2AAA_AAAA_AAAA_AAAA);
        send_item(FN_PROCESS, 8'd128, 63'h5555_5555_5555_5555);
        send_item(FN_CLEAR, 8'd255, '0);            // clear reports the old entry
        send_item(FN_PROCESS, 8'd255, '0);          // empty again after clear
        send_item(FN_PROCESS, 8'd0, '0);
        send_item(FN_CLEAR, 8'd3, TIME_MAX);
        send_item(FN_CLEAR, 8'd0, '0);              // back-to-back clears
        send_item(FN_PROCESS, 8'd1, 63'd1);
    endtask

    // mostly a small hot set of symbols with times close to the stored one,
    // so duplicates and late items are frequent
    task automatic pick_random_item(output logic [FUNC_W-1:0] fn,
                                    output logic [IDX_W-1:0] idx,
                                    output logic [TIME_W-1:0] t);
        int                roll;
        logic [63:0]       wide;
        logic [TIME_W-1:0] prev;
        roll = $urandom_range(99);
        if (roll < 70)
            fn = FN_PROCESS;
        else if (roll < 92)
            fn = FN_CHECK;
        else if (roll < 98)
            fn = FN_SPARE;
        else
            fn = FN_CLEAR;
        if ($urandom_range(9) < 8)
            idx = hot_base + IDX_W'($urandom_range(15));
        else
            idx = IDX_W'($urandom);
        wide = {$urandom, $urandom};
        prev = sb.last_times[idx];
        if (sb.seen_flags[idx]) begin
            roll = $urandom_range(99);
            if (roll < 30)
                t = prev;
            else if (roll < 55)
                t = prev - TIME_W'($urandom_range(1000, 1));
            else if (roll < 95)
                t = prev + TIME_W'($urandom_range(1000, 1));
            else
                t = wide[TIME_W-1:0];
        end else if ($urandom_range(1)) begin
            t = wide[TIME_W-1:0];
        end else begin
            t = TIME_W'($urandom_range(1000));
        end
    endtask

    task automatic run_random(input int count);
        logic [FUNC_W-1:0] fn;
        logic [IDX_W-1:0]  idx;
        logic [TIME_W-1:0] t;
        hot_base = IDX_W'($urandom);
        repeat (count) begin
            pick_random_item(fn, idx, t);
            send_item(fn, idx, t);
        end
    endtask

    initial begin
        sb = new();
        src_idle_pct  = 31;
        sink_idle_pct = 79;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        run_random(600);

        src_idle_pct  = 79;
        sink_idle_pct = 31;
        run_random(600);

        // no idling; the long receiver hold-off makes the block back up
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        hold_request  = 1'b1;
        run_random(500);
        i_s_tvalid <= 1'b0;

        while (sb.pending_verdicts.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.mismatch_count == 0 && sb.pending_verdicts.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
